>>> rtl/mm_pkg.sv
`default_nettype none

package mm_pkg;

  localparam int DimW  = 4;
  localparam int IdxW  = 3;
  localparam int DataW = 32;
  localparam int ProdW = 64;
  localparam int TermW = 48;
  // up to eight rounded terms of 48 bits each
  localparam int AccW  = 51;

  localparam logic [1:0] ActLoadA = 2'd0;
  localparam logic [1:0] ActLoadB = 2'd1;
  localparam logic [1:0] ActStart = 2'd2;

  localparam logic [1:0] RegRowsA = 2'd0;
  localparam logic [1:0] RegColsA = 2'd1;
  localparam logic [1:0] RegRowsB = 2'd2;
  localparam logic [1:0] RegColsB = 2'd3;

  localparam int PcW = 4;
  localparam logic [PcW-1:0] StIdle   = 4'd0;
  localparam logic [PcW-1:0] StCheck  = 4'd1;
  localparam logic [PcW-1:0] StRead   = 4'd2;
  localparam logic [PcW-1:0] StMul    = 4'd3;
  localparam logic [PcW-1:0] StAcc    = 4'd4;
  localparam logic [PcW-1:0] StOut    = 4'd5;
  localparam logic [PcW-1:0] StNext   = 4'd6;
  localparam logic [PcW-1:0] StRet    = 4'd7;
  localparam logic [PcW-1:0] StErr    = 4'd8;
  localparam logic [PcW-1:0] StErrRet = 4'd9;

  typedef enum logic [2:0] {
    CondNever,
    CondAlways,
    CondNoStart,
    CondMismatch,
    CondKMore,
    CondOutBusy,
    CondMore
  } cond_e;

  typedef struct packed {
    logic           ready;
    logic           clr;
    logic           rd;
    logic           mul;
    logic           acc;
    logic           inc_k;
    logic           emit;
    logic           err;
    logic           step_ij;
    cond_e          cond;
    logic [PcW-1:0] target;
  } ucode_t;

  typedef struct packed {
    logic clr;
    logic mul;
    logic acc;
  } mac_ctrl_t;

  function automatic ucode_t ucode_rom(input logic [PcW-1:0] pc);
    ucode_t w;
    w = '0;
    w.cond = CondNever;
    case (pc)
      StIdle: begin
        w.ready  = 1'b1;
        w.cond   = CondNoStart;
        w.target = StIdle;
      end
      StCheck: begin
        w.clr    = 1'b1;
        w.cond   = CondMismatch;
        w.target = StErr;
      end
      StRead: begin
        w.rd = 1'b1;
      end
      StMul: begin
        w.mul = 1'b1;
      end
      StAcc: begin
        w.acc    = 1'b1;
        w.inc_k  = 1'b1;
        w.cond   = CondKMore;
        w.target = StRead;
      end
      StOut: begin
        w.emit   = 1'b1;
        w.cond   = CondOutBusy;
        w.target = StOut;
      end
      StNext: begin
        w.clr     = 1'b1;
        w.step_ij = 1'b1;
        w.cond    = CondMore;
        w.target  = StRead;
      end
      StRet: begin
        w.cond   = CondAlways;
        w.target = StIdle;
      end
      StErr: begin
        w.err    = 1'b1;
        w.cond   = CondOutBusy;
        w.target = StErr;
      end
      StErrRet: begin
        w.cond   = CondAlways;
        w.target = StIdle;
      end
      default: begin
        w.cond   = CondAlways;
        w.target = StIdle;
      end
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

>>> rtl/mm_if.sv
`default_nettype none

interface mm_in_if;
  import mm_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [1:0]              action;
  logic [IdxW-1:0]         row;
  logic [IdxW-1:0]         col;
  logic signed [DataW-1:0] value;

  modport source (output valid, action, row, col, value, input ready);
  modport sink (input valid, action, row, col, value, output ready);
endinterface

interface mm_out_if;
  import mm_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [IdxW-1:0]         out_row;
  logic [IdxW-1:0]         out_col;
  logic signed [DataW-1:0] product;
  logic                    last;
  logic                    error;

  modport source (output valid, out_row, out_col, product, last, error, input ready);
  modport sink (input valid, out_row, out_col, product, last, error, output ready);
endinterface

`default_nettype wire

>>> rtl/mm_mac.sv
`default_nettype none

module mm_mac (
  input  wire logic                            clk_i,
  input  wire mm_pkg::mac_ctrl_t               ctrl_i,
  input  wire logic signed [mm_pkg::DataW-1:0] a_i,
  input  wire logic signed [mm_pkg::DataW-1:0] b_i,
  output logic signed [mm_pkg::DataW-1:0]      sum_o
);
  import mm_pkg::*;

  logic signed [ProdW-1:0] prod_q;
  logic signed [AccW-1:0]  acc_q, acc_d;
  logic signed [ProdW-1:0] rnd;
  logic [TermW-1:0]        term;
  logic                    fits;

  // round half up, then drop the low 16 bits
  assign rnd  = prod_q + 64'sd32768;
  assign term = rnd[ProdW-1:16];

  always_comb begin
    acc_d = acc_q;
    if (ctrl_i.clr) begin
      acc_d = '0;
    end else if (ctrl_i.acc) begin
      acc_d = acc_q + {{(AccW-TermW){term[TermW-1]}}, term};
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul) begin
      prod_q <= a_i * b_i;
    end
    acc_q <= acc_d;
  end

  // saturate to q16.16
  assign fits = (&acc_q[AccW-1:DataW-1]) || !(|acc_q[AccW-1:DataW-1]);

  always_comb begin
    if (fits) begin
      sum_o = acc_q[DataW-1:0];
    end else if (acc_q[AccW-1]) begin
      sum_o = {1'b1, {(DataW-1){1'b0}}};
    end else begin
      sum_o = {1'b0, {(DataW-1){1'b1}}};
    end
  end

endmodule

`default_nettype wire

>>> rtl/matrix_multiply.sv
`default_nettype none

// channel   dir  payload                                  handshake
// in_i      in   action, row, col, value                  valid/ready
// out_o     out  out_row, out_col, product, last, error   valid/ready
// apb       in   rows_a, cols_a, rows_b, cols_b           psel/penable, pready tied high
//
// loads are taken while the sequencer is idle; a start runs a microprogram out of a small rom
// each product element runs read, multiply and accumulate steps per inner term
// on one shared mac, then emit and step; a run adds a check and a return step
// on a dimension mismatch the error step registers the error word after the check step
// reset clears the stores through per-entry valid bits, no clearing pass
// a stalled output holds the sequencer in its emit or error step; inputs wait while running

module matrix_multiply #(
  parameter int MAX_DIM = 8
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  mm_in_if.sink      in_i,
  mm_out_if.source   out_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import mm_pkg::*;

  localparam int Depth    = MAX_DIM * MAX_DIM;
  localparam int AddrW    = $clog2(Depth);
  localparam int DimLimit = (MAX_DIM < 8) ? MAX_DIM : 8;

  function automatic logic [DimW-1:0] clamp_dim(input logic [DimW-1:0] d);
    logic [DimW-1:0] r;
    r = d;
    if (d == '0) begin
      r = 4'd1;
    end else if (d > DimW'(DimLimit)) begin
      r = DimW'(DimLimit);
    end
    return r;
  endfunction

  // configuration registers
  logic [DimW-1:0] rows_a_q, cols_a_q, rows_b_q, cols_b_q;
  logic            cfg_we;

  assign cfg_we = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_a_q <= 4'd1;
      cols_a_q <= 4'd1;
      rows_b_q <= 4'd1;
      cols_b_q <= 4'd1;
    end else if (cfg_we) begin
      unique case (paddr[3:2])
        RegRowsA: rows_a_q <= pwdata[DimW-1:0];
        RegColsA: cols_a_q <= pwdata[DimW-1:0];
        RegRowsB: rows_b_q <= pwdata[DimW-1:0];
        RegColsB: cols_b_q <= pwdata[DimW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (paddr[3:2])
      RegRowsA: prdata[DimW-1:0] = rows_a_q;
      RegColsA: prdata[DimW-1:0] = cols_a_q;
      RegRowsB: prdata[DimW-1:0] = rows_b_q;
      RegColsB: prdata[DimW-1:0] = cols_b_q;
      default:  prdata = '0;
    endcase
  end

  logic [DimW-1:0] ra, ca, rb, cb;
  assign ra = clamp_dim(rows_a_q);
  assign ca = clamp_dim(cols_a_q);
  assign rb = clamp_dim(rows_b_q);
  assign cb = clamp_dim(cols_b_q);

  // sequencer
  logic [PcW-1:0]  pc_q, pc_d;
  ucode_t          uc;
  logic [IdxW-1:0] i_q, j_q, k_q;
  logic            jump;
  logic            in_acc;
  logic            out_busy;
  logic            k_more;
  logic            last_el;
  logic            j_end;

  assign uc       = ucode_rom(pc_q);
  assign in_i.ready = uc.ready;
  assign in_acc   = in_i.valid && in_i.ready;
  assign out_busy = out_o.valid && !out_o.ready;
  assign k_more   = ({1'b0, k_q} + 4'd1) != ca;
  assign j_end    = ({1'b0, j_q} + 4'd1) == cb;
  assign last_el  = (({1'b0, i_q} + 4'd1) == ra) && j_end;

  always_comb begin
    case (uc.cond)
      CondNever:    jump = 1'b0;
      CondAlways:   jump = 1'b1;
      CondNoStart:  jump = !(in_acc && (in_i.action == ActStart));
      CondMismatch: jump = (ca != rb);
      CondKMore:    jump = k_more;
      CondOutBusy:  jump = out_busy;
      CondMore:     jump = !last_el;
      default:      jump = 1'b1;
    endcase
    pc_d = jump ? uc.target : pc_q + 4'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= StIdle;
      i_q  <= '0;
      j_q  <= '0;
      k_q  <= '0;
    end else begin
      pc_q <= pc_d;
      if (uc.clr && !uc.step_ij) begin
        i_q <= '0;
        j_q <= '0;
        k_q <= '0;
      end
      if (uc.inc_k) begin
        k_q <= k_q + 3'd1;
      end
      if (uc.step_ij) begin
        k_q <= '0;
        if (j_end) begin
          j_q <= '0;
          i_q <= i_q + 3'd1;
        end else begin
          j_q <= j_q + 3'd1;
        end
      end
    end
  end

  // element stores with per-entry valid bits
  logic signed [DataW-1:0] mem_a [Depth];
  logic signed [DataW-1:0] mem_b [Depth];
  logic [Depth-1:0]        valid_a_q, valid_b_q;
  logic [AddrW-1:0]        waddr, addr_a, addr_b;
  logic                    in_range, we_a, we_b;
  logic signed [DataW-1:0] rd_a_q, rd_b_q;
  logic                    rv_a_q, rv_b_q;
  logic signed [DataW-1:0] op_a, op_b;

  assign in_range = (int'(in_i.row) < MAX_DIM) && (int'(in_i.col) < MAX_DIM);
  assign waddr    = AddrW'(int'(in_i.row) * MAX_DIM + int'(in_i.col));
  assign we_a     = in_acc && in_range && (in_i.action == ActLoadA);
  assign we_b     = in_acc && in_range && (in_i.action == ActLoadB);
  assign addr_a   = AddrW'(int'(i_q) * MAX_DIM + int'(k_q));
  assign addr_b   = AddrW'(int'(k_q) * MAX_DIM + int'(j_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_a_q <= '0;
      valid_b_q <= '0;
    end else begin
      if (we_a) begin
        valid_a_q[waddr] <= 1'b1;
      end
      if (we_b) begin
        valid_b_q[waddr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (we_a) begin
      mem_a[waddr] <= in_i.value;
    end
    if (we_b) begin
      mem_b[waddr] <= in_i.value;
    end
    if (uc.rd) begin
      rd_a_q <= mem_a[addr_a];
      rd_b_q <= mem_b[addr_b];
      rv_a_q <= valid_a_q[addr_a];
      rv_b_q <= valid_b_q[addr_b];
    end
  end

  assign op_a = rv_a_q ? rd_a_q : '0;
  assign op_b = rv_b_q ? rd_b_q : '0;

  mac_ctrl_t               mac_ctrl;
  logic signed [DataW-1:0] sum;

  assign mac_ctrl.clr = uc.clr;
  assign mac_ctrl.mul = uc.mul;
  assign mac_ctrl.acc = uc.acc;

  mm_mac u_mac (
    .clk_i  (clk_i),
    .ctrl_i (mac_ctrl),
    .a_i    (op_a),
    .b_i    (op_b),
    .sum_o  (sum)
  );

  // output word register
  logic                    out_valid_q;
  logic [IdxW-1:0]         out_row_q, out_col_q;
  logic signed [DataW-1:0] product_q;
  logic                    last_q, error_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if ((uc.emit || uc.err) && !out_busy) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (uc.emit && !out_busy) begin
      out_row_q <= i_q;
      out_col_q <= j_q;
      product_q <= sum;
      last_q    <= last_el;
      error_q   <= 1'b0;
    end else if (uc.err && !out_busy) begin
      out_row_q <= '0;
      out_col_q <= '0;
      product_q <= '0;
      last_q    <= 1'b1;
      error_q   <= 1'b1;
    end
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.out_row = out_row_q;
  assign out_o.out_col = out_col_q;
  assign out_o.product = product_q;
  assign out_o.last    = last_q;
  assign out_o.error   = error_q;

endmodule

`default_nettype wire

>>> bench/tb_matrix_multiply.sv
`timescale 1ns / 1ps

module tb_matrix_multiply;
  import mm_pkg::*;

  localparam int MaxDim        = 8;
  localparam int LongHold      = 400;
  localparam int WatchdogLimit = 3000;
  localparam int SettleCycles  = 12;
  localparam int WordTarget    = 300;
  localparam logic [1:0] ActNone = 2'd3;
  localparam longint QMax = 64'sh0000_0000_7FFF_FFFF;
  localparam longint QMin = 64'shFFFF_FFFF_8000_0000;

  typedef struct packed {
    logic [1:0]              action;
    logic [IdxW-1:0]         row;
    logic [IdxW-1:0]         col;
    logic signed [DataW-1:0] value;
  } mm_word_t;

  typedef struct packed {
    logic [IdxW-1:0]         row;
    logic [IdxW-1:0]         col;
    logic signed [DataW-1:0] product;
    logic                    last;
    logic                    err;
  } product_elem_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  mm_in_if  in_bus ();
  mm_out_if out_bus ();

  matrix_multiply #(.MAX_DIM(MaxDim)) DUT (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_bus),
    .out_o   (out_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // shadow of the block: dimension registers and both element stores
  logic [3:0] cfg_rows_a = 4'd1;
  logic [3:0] cfg_cols_a = 4'd1;
  logic [3:0] cfg_rows_b = 4'd1;
  logic [3:0] cfg_cols_b = 4'd1;
  logic signed [DataW-1:0] mat_a [MaxDim*MaxDim] = '{default: '0};
  logic signed [DataW-1:0] mat_b [MaxDim*MaxDim] = '{default: '0};

  mm_word_t      items_to_send [$];
  product_elem_t products_due [$];
  mm_word_t      word_on_bus;

  int words_queued = 0;
  int words_done   = 0;
  int real_words   = 0;
  int n_starts     = 0;
  int n_checked    = 0;
  int n_dim_errors = 0;
  int n_fail       = 0;
  int send_gap     = 0;
  int recv_gap     = 0;
  int hold_left    = 0;
  int idle_cycles  = 0;
  bit calm           = 1'b0;
  bit want_long_hold = 1'b0;
  bit long_hold_done = 1'b0;

  function automatic int eff_dim(input logic [3:0] d);
    if (d == 4'd0) return 1;
    if (d > MaxDim) return MaxDim;
    return int'(d);
  endfunction

  task automatic compute_products(input mm_word_t w);
    int ra, ca, rb, cb;
    longint acc_sum, term;
    product_elem_t e;
    case (w.action)
      ActLoadA: mat_a[w.row * MaxDim + w.col] = w.value;
      ActLoadB: mat_b[w.row * MaxDim + w.col] = w.value;
      ActStart: begin
        n_starts++;
        ra = eff_dim(cfg_rows_a);
        ca = eff_dim(cfg_cols_a);
        rb = eff_dim(cfg_rows_b);
        cb = eff_dim(cfg_cols_b);
        if (ca != rb) begin
          e.row = '0;
          e.col = '0;
          e.product = '0;
          e.last = 1'b1;
          e.err = 1'b1;
          products_due.push_back(e);
        end else begin
          for (int i = 0; i < ra; i++) begin
            for (int j = 0; j < cb; j++) begin
              acc_sum = 0;
              for (int k = 0; k < ca; k++) begin
                term = longint'(mat_a[i * MaxDim + k]) * longint'(mat_b[k * MaxDim + j]);
                // round half toward plus infinity back to q16.16
                acc_sum += (term + 64'sd32768) >>> 16;
              end
              e.row = i[IdxW-1:0];
              e.col = j[IdxW-1:0];
              if (acc_sum > QMax) e.product = 32'sh7FFF_FFFF;
              else if (acc_sum < QMin) e.product = 32'sh8000_0000;
              else e.product = acc_sum[DataW-1:0];
              e.last = (i == ra - 1) && (j == cb - 1);
              e.err = 1'b0;
              products_due.push_back(e);
            end
          end
        end
      end
      default: ;
    endcase
  endtask

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_bus.valid  <= 1'b0;
      in_bus.action <= '0;
      in_bus.row    <= '0;
      in_bus.col    <= '0;
      in_bus.value  <= '0;
      send_gap = 0;
    end else begin
      if (in_bus.valid && in_bus.ready) begin
        compute_products(word_on_bus);
        words_done++;
      end
      if (!in_bus.valid || in_bus.ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_bus.valid <= 1'b0;
        end else if (!calm && items_to_send.size() != 0 && $urandom_range(0, 11) == 0) begin
          send_gap = $urandom_range(0, 15);
          in_bus.valid <= 1'b0;
        end else if (items_to_send.size() != 0) begin
          word_on_bus = items_to_send.pop_front();
          in_bus.valid  <= 1'b1;
          in_bus.action <= word_on_bus.action;
          in_bus.row    <= word_on_bus.row;
          in_bus.col    <= word_on_bus.col;
          in_bus.value  <= word_on_bus.value;
        end else begin
          in_bus.valid <= 1'b0;
        end
      end
    end
  end

  // monitor and output back-pressure
  always @(posedge clk_i or negedge rst_ni) begin
    product_elem_t got;
    if (!rst_ni) begin
      out_bus.ready <= 1'b0;
      recv_gap = 0;
      hold_left = 0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        if (products_due.size() == 0) begin
          $error("word with nothing expected: out_row %0d out_col %0d product %0d",
                 out_bus.out_row, out_bus.out_col, out_bus.product);
          n_fail++;
        end else begin
          got = products_due.pop_front();
          n_checked++;
          if (got.err) n_dim_errors++;
          if (out_bus.out_row !== got.row) begin
            $error("out_row: expected %0d, got %0d", got.row, out_bus.out_row);
            n_fail++;
          end
          if (out_bus.out_col !== got.col) begin
            $error("out_col: expected %0d, got %0d", got.col, out_bus.out_col);
            n_fail++;
          end
          if (out_bus.product !== got.product) begin
            $error("product: expected %0d, got %0d", got.product, out_bus.product);
            n_fail++;
          end
          if (out_bus.last !== got.last) begin
            $error("last: expected %0d, got %0d", got.last, out_bus.last);
            n_fail++;
          end
          if (out_bus.error !== got.err) begin
            $error("error: expected %0d, got %0d", got.err, out_bus.error);
            n_fail++;
          end
        end
      end
      if (want_long_hold && !long_hold_done) begin
        long_hold_done = 1'b1;
        hold_left = LongHold;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_bus.ready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        out_bus.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        recv_gap = $urandom_range(0, 15);
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= 1'b1;
      end
    end
  end

  // watchdog on cycles with no word moving either way
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= WatchdogLimit) begin
        $display("watchdog: %0d cycles without a word, %0d products still due",
                 idle_cycles, products_due.size());
        $display("** matrix_multiply: FAILED **");
        $finish;
      end
    end
  end

  task automatic queue_word(input logic [1:0] act, input int r, input int c,
                            input logic signed [DataW-1:0] v);
    mm_word_t w;
    w.action = act;
    w.row = r[IdxW-1:0];
    w.col = c[IdxW-1:0];
    w.value = v;
    items_to_send.push_back(w);
    words_queued++;
    if (act != ActNone) real_words++;
  endtask

  // wait until every word is taken and every product is back, then let the sequencer finish
  task automatic settle();
    do @(posedge clk_i); while (words_done != words_queued || products_due.size() != 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic apb_write(input logic [1:0] idx, input logic [3:0] v);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= ($urandom() & 32'hFFFF_FFF0) | {28'd0, v};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      RegRowsA: cfg_rows_a = v;
      RegColsA: cfg_cols_a = v;
      RegRowsB: cfg_rows_b = v;
      RegColsB: cfg_cols_b = v;
      default: ;
    endcase
  endtask

  task automatic set_dims(input logic [3:0] ra, input logic [3:0] ca,
                          input logic [3:0] rb, input logic [3:0] cb);
    settle();
    apb_write(RegRowsA, ra);
    apb_write(RegColsA, ca);
    apb_write(RegRowsB, rb);
    apb_write(RegColsB, cb);
  endtask

  function automatic logic signed [DataW-1:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 32'sh7FFF_FFFF;
      1: return 32'sh8000_0000;
      2, 3: return 32'($urandom());
      4: return 32'sh0001_0000;
      default: return 32'(int'($urandom_range(0, 524288)) - 262144);
    endcase
  endfunction

  function automatic logic [3:0] pick_dim();
    case ($urandom_range(0, 19))
      0, 1, 2: return 4'd8;
      3: return 4'd0;
      4: return 4'($urandom_range(9, 15));
      5, 6: return 4'($urandom_range(5, 7));
      default: return 4'($urandom_range(1, 4));
    endcase
  endfunction

  // one job, mostly with matching inner dimensions: dimensions, loads over the used area, some noise, then starts
  task automatic random_phase(input bit squeeze);
    logic [3:0] ra, ca, rb, cb;
    int era, eca, erb, ecb, span, keep, n_go;
    if (squeeze) begin
      ra = 4'd4;
      ca = 4'd4;
      rb = 4'd4;
      cb = 4'd4;
    end else begin
      ra = pick_dim();
      ca = pick_dim();
      cb = pick_dim();
      if ($urandom_range(0, 7) == 0) rb = pick_dim();
      else if (eff_dim(ca) == MaxDim) rb = 4'($urandom_range(MaxDim, 15));
      else if (eff_dim(ca) == 1) rb = 4'($urandom_range(0, 1));
      else rb = ca;
    end
    set_dims(ra, ca, rb, cb);
    era = eff_dim(ra);
    eca = eff_dim(ca);
    erb = eff_dim(rb);
    ecb = eff_dim(cb);
    span = era * eca + erb * ecb;
    keep = (span <= 20) ? 100 : 2000 / span;
    for (int i = 0; i < era; i++) begin
      for (int k = 0; k < eca; k++) begin
        if ($urandom_range(1, 100) <= keep) queue_word(ActLoadA, i, k, pick_value());
      end
    end
    for (int k = 0; k < erb; k++) begin
      for (int j = 0; j < ecb; j++) begin
        if ($urandom_range(1, 100) <= keep) queue_word(ActLoadB, k, j, pick_value());
      end
    end
    repeat ($urandom_range(0, 2)) begin
      queue_word(2'($urandom_range(0, 1)), $urandom_range(0, 7), $urandom_range(0, 7),
                 pick_value());
    end
    if ($urandom_range(0, 7) == 0) begin
      queue_word(ActNone, $urandom_range(0, 7), $urandom_range(0, 7), pick_value());
    end
    n_go = squeeze ? 3 : (($urandom_range(0, 3) == 0) ? 2 : 1);
    // output held off for a long stretch while starts keep coming
    if (squeeze) want_long_hold = 1'b1;
    repeat (n_go) begin
      queue_word(ActStart, $urandom_range(0, 7), $urandom_range(0, 7), 32'($urandom()));
    end
  endtask

  initial begin
    int phase_no;
    rst_ni  <= 1'b0;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= '0;
    pwdata  <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // 1x1 by 1x1 on cleared stores
    queue_word(ActStart, 0, 0, 0);
    // saturation both ways
    queue_word(ActLoadA, 0, 0, 32'sh7FFF_FFFF);
    queue_word(ActLoadB, 0, 0, 32'sh7FFF_FFFF);
    queue_word(ActStart, 7, 7, 32'shFFFF_FFFF);
    queue_word(ActLoadB, 0, 0, 32'sh8000_0000);
    queue_word(ActStart, 0, 0, 0);
    queue_word(ActLoadA, 0, 0, 32'sh8000_0000);
    queue_word(ActStart, 0, 0, 0);
    // exact half rounds up, for both signs
    queue_word(ActLoadA, 0, 0, 32'sd1);
    queue_word(ActLoadB, 0, 0, 32'sh0000_8000);
    queue_word(ActStart, 0, 0, 0);
    queue_word(ActLoadA, 0, 0, 32'shFFFF_FFFF);
    queue_word(ActStart, 0, 0, 0);
    // unused action does nothing
    queue_word(ActNone, 5, 2, 32'($urandom()));
    // loads outside the current dimensions, used later
    queue_word(ActLoadA, 7, 7, pick_value());
    queue_word(ActLoadB, 7, 7, pick_value());
    queue_word(ActLoadB, 7, 0, pick_value());
    queue_word(ActLoadA, 0, 7, pick_value());
    // inner dimensions differ
    set_dims(4'd2, 4'd3, 4'd2, 4'd1);
    queue_word(ActStart, 3, 3, 0);
    // zero acts as one, above eight acts as eight
    set_dims(4'd0, 4'd15, 4'd8, 4'd0);
    queue_word(ActStart, 0, 0, 0);
    set_dims(4'd15, 4'd9, 4'd12, 4'd15);
    queue_word(ActStart, 0, 0, 0);

    phase_no = 0;
    while (real_words < WordTarget) begin
      if (real_words > WordTarget * 4 / 5) calm = 1'b1;
      random_phase(phase_no == 4);
      phase_no++;
    end

    settle();
    repeat (20) @(posedge clk_i);
    $display("run covered %0d input words with %0d multiplies over %0d job phases",
             words_done, n_starts, phase_no);
    $display("checked %0d result words, %0d of them dimension errors",
             n_checked, n_dim_errors);
    if (n_fail == 0) begin
      $display("** matrix_multiply: PASSED **");
    end else begin
      $display("** matrix_multiply: FAILED **");
    end
    $finish;
  end

endmodule
